@@ rtl/hs_pkg.sv @@
`timescale 1ns / 1ps

package hs_pkg;

    // Fixed field widths and parameter defaults
    localparam int VALUE_W        = 32;
    localparam int DEPTH_DEF      = 64;
    localparam int DATA_WIDTH_DEF = 32;

    // Program counter width and step addresses of the sort program
    localparam int STEP_W = 5;

    localparam logic [STEP_W-1:0] ST_INIT   = 5'd0;
    localparam logic [STEP_W-1:0] ST_BLOOP  = 5'd1;
    localparam logic [STEP_W-1:0] ST_BSTEP  = 5'd2;
    localparam logic [STEP_W-1:0] ST_ENTRY0 = 5'd3;
    localparam logic [STEP_W-1:0] ST_ENTRY1 = 5'd4;
    localparam logic [STEP_W-1:0] ST_LEFT   = 5'd5;
    localparam logic [STEP_W-1:0] ST_RIGHT  = 5'd6;
    localparam logic [STEP_W-1:0] ST_PICK   = 5'd7;
    localparam logic [STEP_W-1:0] ST_CMP    = 5'd8;
    localparam logic [STEP_W-1:0] ST_MOVE   = 5'd9;
    localparam logic [STEP_W-1:0] ST_FIN    = 5'd10;
    localparam logic [STEP_W-1:0] ST_XLOOP  = 5'd11;
    localparam logic [STEP_W-1:0] ST_XROOT  = 5'd12;
    localparam logic [STEP_W-1:0] ST_XTOP   = 5'd13;
    localparam logic [STEP_W-1:0] ST_XSWAP  = 5'd14;
    localparam logic [STEP_W-1:0] ST_EMRD   = 5'd15;
    localparam logic [STEP_W-1:0] ST_EMOUT  = 5'd16;
    localparam logic [STEP_W-1:0] ST_DONE   = 5'd17;

    // Payload words
    typedef struct packed {
        logic signed [VALUE_W-1:0] value_in;
        logic                      last_in;
    } hs_item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value_out;
        logic                      last_out;
        logic                      dropped;
    } hs_result_t;

    // Jump conditions
    typedef enum logic [2:0] {
        JC_NONE,
        JC_ALWAYS,
        JC_N_SMALL,
        JC_I_ZERO,
        JC_NO_CHILD,
        JC_NOT_LESS,
        JC_PHASE,
        JC_TOP_ZERO
    } hs_jc_t;

    // Memory read address select
    typedef enum logic [2:0] {
        RD_NONE,
        RD_NODE,
        RD_CHILD_CALC,
        RD_CHILD1,
        RD_ROOT,
        RD_TOP,
        RD_K
    } hs_rd_t;

    // Memory write select
    typedef enum logic [1:0] {
        WR_NONE,
        WR_NODE_C,
        WR_NODE_A,
        WR_TOP_C
    } hs_wr_t;

    // Control word: one per program step
    typedef struct packed {
        hs_jc_t            jc;
        logic              jc_inv;
        logic [STEP_W-1:0] target;
        hs_rd_t            rd;
        hs_wr_t            wr;
        logic              ld_a;
        logic              ld_c;
        logic              pick;
        logic              ld_child;
        logic              node_child;
        logic              node_root;
        logic              top_dec;
        logic              build_step;
        logic              init;
        logic              phase_clr;
        logic              emit;
        logic              done;
    } hs_ctl_t;

    // Datapath status seen by the sequencer
    typedef struct packed {
        logic n_small;
        logic i_zero;
        logic no_child;
        logic not_less;
        logic phase;
        logic top_zero;
        logic emit_last;
    } hs_flags_t;

    // Microcode table
    function automatic hs_ctl_t ucode(input logic [STEP_W-1:0] pc);
        hs_ctl_t c;
        c = '0;
        unique case (pc)
            ST_INIT:
            begin
                c.init   = 1'b1;
                c.jc     = JC_N_SMALL;
                c.target = ST_EMRD;
            end
            ST_BLOOP:
            begin
                c.jc     = JC_I_ZERO;
                c.target = ST_XLOOP;
            end
            ST_BSTEP:
            begin
                c.build_step = 1'b1;
            end
            ST_ENTRY0:
            begin
                c.rd = RD_NODE;
            end
            ST_ENTRY1:
            begin
                c.ld_a = 1'b1;
            end
            ST_LEFT:
            begin
                c.rd       = RD_CHILD_CALC;
                c.ld_child = 1'b1;
                c.jc       = JC_NO_CHILD;
                c.target   = ST_FIN;
            end
            ST_RIGHT:
            begin
                c.ld_c = 1'b1;
                c.rd   = RD_CHILD1;
            end
            ST_PICK:
            begin
                c.pick = 1'b1;
            end
            ST_CMP:
            begin
                c.jc     = JC_NOT_LESS;
                c.target = ST_FIN;
            end
            ST_MOVE:
            begin
                c.wr         = WR_NODE_C;
                c.node_child = 1'b1;
                c.jc         = JC_ALWAYS;
                c.target     = ST_LEFT;
            end
            ST_FIN:
            begin
                c.wr     = WR_NODE_A;
                c.jc     = JC_PHASE;
                c.target = ST_BLOOP;
            end
            ST_XLOOP:
            begin
                c.phase_clr = 1'b1;
                c.jc        = JC_TOP_ZERO;
                c.target    = ST_EMRD;
            end
            ST_XROOT:
            begin
                c.rd = RD_ROOT;
            end
            ST_XTOP:
            begin
                c.ld_c = 1'b1;
                c.rd   = RD_TOP;
            end
            ST_XSWAP:
            begin
                c.ld_a      = 1'b1;
                c.wr        = WR_TOP_C;
                c.node_root = 1'b1;
                c.top_dec   = 1'b1;
                c.jc        = JC_ALWAYS;
                c.target    = ST_LEFT;
            end
            ST_EMRD:
            begin
                c.rd = RD_K;
            end
            ST_EMOUT:
            begin
                // loop back until the final word is out
                c.emit   = 1'b1;
                c.jc     = JC_NONE;
                c.jc_inv = 1'b1;
                c.target = ST_EMRD;
            end
            ST_DONE:
            begin
                c.done = 1'b1;
            end
            default:
            begin
                c.done = 1'b1;
            end
        endcase
        return c;
    endfunction

endpackage

@@ rtl/hs_sequencer.sv @@
`timescale 1ns / 1ps

module hs_sequencer
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            go,
    input  hs_pkg::hs_flags_t flags,
    output hs_pkg::hs_ctl_t   ctl,
    output logic            busy
);

    localparam int SW = hs_pkg::STEP_W;

    logic [SW-1:0] pc_reg;
    logic [SW-1:0] pc_next;
    logic          run_reg;
    logic          run_next;
    logic          cond;
    logic          taken;
    hs_pkg::hs_ctl_t word;

    // Fetch the control word of the current step
    always_comb
    begin
        word = hs_pkg::ucode(pc_reg);
        ctl  = run_reg ? word : hs_pkg::hs_ctl_t'('0);
    end

    // Evaluate the jump condition
    always_comb
    begin
        unique case (word.jc)
            hs_pkg::JC_NONE:     cond = 1'b0;
            hs_pkg::JC_ALWAYS:   cond = 1'b1;
            hs_pkg::JC_N_SMALL:  cond = flags.n_small;
            hs_pkg::JC_I_ZERO:   cond = flags.i_zero;
            hs_pkg::JC_NO_CHILD: cond = flags.no_child;
            hs_pkg::JC_NOT_LESS: cond = flags.not_less;
            hs_pkg::JC_PHASE:    cond = flags.phase;
            hs_pkg::JC_TOP_ZERO: cond = flags.top_zero;
            default:             cond = 1'b0;
        endcase
        // inverted form tests for "not the final word"
        taken = word.jc_inv ? !flags.emit_last : cond;
    end

    // Advance or jump
    always_comb
    begin
        pc_next  = pc_reg;
        run_next = run_reg;
        if (go)
        begin
            pc_next  = hs_pkg::ST_INIT;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            pc_next = taken ? word.target : pc_reg + SW'(1);
            if (word.done)
            begin
                run_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg  <= hs_pkg::ST_INIT;
            run_reg <= 1'b0;
        end
        else
        begin
            pc_reg  <= pc_next;
            run_reg <= run_next;
        end
    end

    assign busy = run_reg;

endmodule

@@ rtl/hs_datapath.sv @@
`timescale 1ns / 1ps

module hs_datapath
#(
    parameter int DEPTH      = hs_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = hs_pkg::DATA_WIDTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  hs_pkg::hs_item_t   item,
    input  hs_pkg::hs_ctl_t    ctl,
    output hs_pkg::hs_flags_t  flags,
    output logic               strobe,
    output hs_pkg::hs_result_t result
);

    localparam int VW = hs_pkg::VALUE_W;
    localparam int SW = (DATA_WIDTH < VW) ? DATA_WIDTH : VW;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    // Heap store
    logic signed [SW-1:0] mem [DEPTH];
    logic signed [SW-1:0] rdata_reg;
    logic [AW-1:0]        raddr;
    logic                 rd_en;
    logic [AW-1:0]        waddr;
    logic signed [SW-1:0] wdata;
    logic                 wr_en;

    // Control registers
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic          ovf_reg;
    logic          ovf_next;

    // Sequencer working registers
    logic [CW-1:0]        i_reg;
    logic [CW-1:0]        i_next;
    logic [CW-1:0]        k_reg;
    logic [CW-1:0]        k_next;
    logic [AW-1:0]        node_reg;
    logic [AW-1:0]        node_next;
    logic [AW-1:0]        child_reg;
    logic [AW-1:0]        child_next;
    logic [AW-1:0]        top_reg;
    logic [AW-1:0]        top_next;
    logic                 phase_reg;
    logic                 phase_next;
    logic signed [SW-1:0] a_reg;
    logic signed [SW-1:0] a_next;
    logic signed [SW-1:0] c_reg;
    logic signed [SW-1:0] c_next;

    logic [AW:0]   child_calc;
    logic          right_wins;
    logic [CW-1:0] k_inc;

    assign child_calc = {node_reg, 1'b1};
    assign right_wins = (child_reg < top_reg) && (c_reg < rdata_reg);
    assign k_inc      = k_reg + CW'(1);

    // Status for the sequencer
    always_comb
    begin
        flags.n_small   = cnt_reg < CW'(2);
        flags.i_zero    = i_reg == '0;
        flags.no_child  = child_calc > {1'b0, top_reg};
        flags.not_less  = !(a_reg < c_reg);
        flags.phase     = phase_reg;
        flags.top_zero  = top_reg == '0;
        flags.emit_last = k_inc == cnt_reg;
    end

    // Select the read address
    always_comb
    begin
        rd_en = 1'b1;
        raddr = '0;
        case (ctl.rd)
            hs_pkg::RD_NODE:       raddr = node_reg;
            hs_pkg::RD_CHILD_CALC: raddr = child_calc[AW-1:0];
            hs_pkg::RD_CHILD1:     raddr = child_reg + AW'(1);
            hs_pkg::RD_ROOT:       raddr = '0;
            hs_pkg::RD_TOP:        raddr = top_reg;
            hs_pkg::RD_K:          raddr = k_reg[AW-1:0];
            default:               rd_en = 1'b0;
        endcase
    end

    // Select the write port: loads while idle, sequencer while busy
    always_comb
    begin
        wr_en = 1'b0;
        waddr = '0;
        wdata = a_reg;
        if (load)
        begin
            wr_en = cnt_reg < CW'(DEPTH);
            waddr = cnt_reg[AW-1:0];
            wdata = item.value_in[SW-1:0];
        end
        else
        begin
            case (ctl.wr)
                hs_pkg::WR_NODE_C:
                begin
                    wr_en = 1'b1;
                    waddr = node_reg;
                    wdata = c_reg;
                end
                hs_pkg::WR_NODE_A:
                begin
                    wr_en = 1'b1;
                    waddr = node_reg;
                    wdata = a_reg;
                end
                hs_pkg::WR_TOP_C:
                begin
                    wr_en = 1'b1;
                    waddr = top_reg;
                    wdata = c_reg;
                end
                default:
                begin
                    wr_en = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    // Update count, overflow and working registers
    always_comb
    begin
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;
        i_next     = i_reg;
        k_next     = k_reg;
        node_next  = node_reg;
        child_next = child_reg;
        top_next   = top_reg;
        phase_next = phase_reg;
        a_next     = a_reg;
        c_next     = c_reg;

        // count the word or flag it dropped
        if (load)
        begin
            if (cnt_reg < CW'(DEPTH))
            begin
                cnt_next = cnt_reg + CW'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
        if (ctl.init)
        begin
            i_next     = cnt_reg;
            top_next   = AW'(cnt_reg - CW'(1));
            k_next     = '0;
            phase_next = 1'b1;
        end
        if (ctl.build_step)
        begin
            i_next    = i_reg - CW'(1);
            node_next = AW'(i_reg - CW'(1));
        end
        if (ctl.phase_clr)
        begin
            phase_next = 1'b0;
        end
        if (ctl.ld_a)
        begin
            a_next = rdata_reg;
        end
        if (ctl.ld_c)
        begin
            c_next = rdata_reg;
        end
        if (ctl.ld_child)
        begin
            child_next = child_calc[AW-1:0];
        end
        // take the right child when it is larger
        if (ctl.pick && right_wins)
        begin
            c_next     = rdata_reg;
            child_next = child_reg + AW'(1);
        end
        if (ctl.node_child)
        begin
            node_next = child_reg;
        end
        if (ctl.node_root)
        begin
            node_next = '0;
        end
        if (ctl.top_dec)
        begin
            top_next = top_reg - AW'(1);
        end
        if (ctl.emit)
        begin
            k_next = k_inc;
        end
        // drop the set once the last word is out
        if (ctl.done)
        begin
            cnt_next = '0;
            ovf_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg     <= i_next;
        k_reg     <= k_next;
        node_reg  <= node_next;
        child_reg <= child_next;
        top_reg   <= top_next;
        a_reg     <= a_next;
        c_reg     <= c_next;
    end

    // Drive the result word
    always_comb
    begin
        strobe           = ctl.emit;
        result.value_out = VW'(rdata_reg);
        result.last_out  = k_inc == cnt_reg;
        result.dropped   = ovf_reg;
    end

endmodule

@@ rtl/heap_sort_unit.sv @@
`timescale 1ns / 1ps

// Heap sort unit: collects signed words, then returns them in ascending order.
// Input channel: item carries value_in and last_in; a word is taken at a rising
// edge with start high and busy low. A load gives no result. Words beyond
// DEPTH are discarded and remembered as dropped.
// The word with last_in set raises busy and starts the sort program: a max-heap
// is built by sifting each node down, then the root is swapped to the end and
// sifted down again until one entry is left. The heap memory has one read and
// one write port.
// Output channel: strobe marks result (value_out, last_out, dropped) for one
// cycle; last_out is set on the final one, dropped the same on every word of
// the set. The receiver cannot hold results off.
// After the last result busy falls, and the count and dropped flag clear.
// Reset clears the count, the dropped flag and the sequencer; memory contents
// are not cleared, since no entry's value is used before it is loaded.
module heap_sort_unit
#(
    parameter int DEPTH      = hs_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = hs_pkg::DATA_WIDTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  hs_pkg::hs_item_t   item,
    output logic               strobe,
    output hs_pkg::hs_result_t result
);

    logic              load;
    logic              go;
    hs_pkg::hs_ctl_t   ctl;
    hs_pkg::hs_flags_t flags;

    // Take a word whenever idle; the flagged last word starts the program
    assign load = start && !busy;
    assign go   = load && item.last_in;

    hs_sequencer u_seq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (go),
        .flags (flags),
        .ctl   (ctl),
        .busy  (busy)
    );

    hs_datapath
    #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    )
    u_dp
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (load),
        .item   (item),
        .ctl    (ctl),
        .flags  (flags),
        .strobe (strobe),
        .result (result)
    );

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    localparam int CAPACITY     = hs_pkg::DEPTH_DEF;
    localparam int RANDOM_WORDS = 225;
    localparam int STALL_LIMIT  = 20000;
    localparam int SHOWN_ERRORS = 10;

    // Track loaded words and hold the sorted words the block must return
    class sort_tracker;
        logic signed [hs_pkg::VALUE_W-1:0] heap_mem [CAPACITY];
        int unsigned held;
        bit          overflow;
        hs_pkg::hs_result_t sorted_words [$];
        int unsigned mismatches;

        function new();
            held       = 0;
            overflow   = 1'b0;
            mismatches = 0;
        endfunction

        // Sift one node down over heap entries 0..bound
        function void sift_down(int unsigned node, int unsigned bound);
            int unsigned child;
            logic signed [hs_pkg::VALUE_W-1:0] tmp;
            child = 2 * node + 1;
            while (child <= bound)
            begin
                if (child < bound && heap_mem[child] < heap_mem[child + 1])
                    child++;
                if (!(heap_mem[node] < heap_mem[child]))
                    break;
                tmp             = heap_mem[node];
                heap_mem[node]  = heap_mem[child];
                heap_mem[child] = tmp;
                node            = child;
                child           = 2 * node + 1;
            end
        endfunction

        // Build a max-heap, then move the root to the end until one entry is left
        function void heap_order(int unsigned n);
            logic signed [hs_pkg::VALUE_W-1:0] tmp;
            if (n < 2)
                return;
            for (int unsigned i = n; i > 0; i--)
                sift_down(i - 1, n - 1);
            for (int unsigned m = n; m > 1; m--)
            begin
                tmp             = heap_mem[0];
                heap_mem[0]     = heap_mem[m - 1];
                heap_mem[m - 1] = tmp;
                sift_down(0, m - 2);
            end
        endfunction

        // Store an accepted word; on the last word queue the sorted set
        function void load_word(hs_pkg::hs_item_t w);
            hs_pkg::hs_result_t r;
            if (held < CAPACITY)
            begin
                heap_mem[held] = w.value_in;
                held++;
            end
            else
            begin
                overflow = 1'b1;
            end
            if (w.last_in)
            begin
                heap_order(held);
                for (int unsigned k = 0; k < held; k++)
                begin
                    r.value_out = heap_mem[k];
                    r.last_out  = (k + 1 == held);
                    r.dropped   = overflow;
                    sorted_words.push_back(r);
                end
                held     = 0;
                overflow = 1'b0;
            end
        endfunction

        // Compare one returned word with the oldest sorted word
        function void check_word(hs_pkg::hs_result_t got);
            hs_pkg::hs_result_t want;
            if (sorted_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= SHOWN_ERRORS)
                    $display("%0t: unexpected word value %0d last %0b dropped %0b",
                             $time, got.value_out, got.last_out, got.dropped);
                return;
            end
            want = sorted_words.pop_front();
            if (got.value_out !== want.value_out || got.last_out !== want.last_out ||
                got.dropped !== want.dropped)
            begin
                mismatches++;
                if (mismatches <= SHOWN_ERRORS)
                    $display({"%0t: expected value %0d last %0b dropped %0b, ",
                              "got value %0d last %0b dropped %0b"},
                             $time, want.value_out, want.last_out, want.dropped,
                             got.value_out, got.last_out, got.dropped);
            end
        endfunction

        function int unsigned pending();
            return sorted_words.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n  = 1'b0;
    logic               start  = 1'b0;
    hs_pkg::hs_item_t   item   = '0;
    logic               busy;
    logic               strobe;
    hs_pkg::hs_result_t result;

    sort_tracker tracker;
    int unsigned idle_pct    = 0;
    int unsigned words_sent  = 0;
    int unsigned quiet_cycles = 0;

    heap_sort_unit DUT
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .strobe (strobe),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Pick a value: mostly random, sometimes extremes or a narrow range for ties
    function automatic logic signed [hs_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return {1'b1, {(hs_pkg::VALUE_W - 1){1'b0}}};
            1: return {1'b0, {(hs_pkg::VALUE_W - 1){1'b1}}};
            2, 3: return $signed($urandom_range(8)) - 4;
            default: return $urandom;
        endcase
    endfunction

    // Offer one word, idling at random first, and hold it until taken
    task automatic send_word(input logic signed [hs_pkg::VALUE_W-1:0] v, input logic last);
        hs_pkg::hs_item_t w;
        w.value_in = v;
        w.last_in  = last;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        item  <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        tracker.load_word(w);
        words_sent++;
    endtask

    task automatic send_set(input int unsigned n);
        for (int unsigned i = 0; i < n; i++)
            send_word(pick_value(), i == n - 1);
    endtask

    // Hold the sender until every sorted word is back and the block is idle
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (tracker.pending() > 0 || busy)
            @(posedge clk);
    endtask

    // Check every returned word
    always @(posedge clk)
    begin
        if (rst_n && strobe === 1'b1)
            tracker.check_word(result);
    end

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || strobe === 1'b1)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned phase_target;
        tracker = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed sets: single word, extremes, ties, reversed order
        idle_pct = 13;
        send_word(32'sh7FFF_FFFF, 1'b1);
        send_word(32'sh8000_0000, 1'b0);
        send_word(32'sh7FFF_FFFF, 1'b1);
        send_word(32'sh0000_0000, 1'b0);
        send_word(-32'sd1, 1'b0);
        send_word(32'sd1, 1'b0);
        send_word(32'sh7FFF_FFFF, 1'b0);
        send_word(32'sh8000_0000, 1'b1);
        send_word(32'sd5, 1'b0);
        send_word(32'sd5, 1'b0);
        send_word(-32'sd5, 1'b0);
        send_word(32'sd5, 1'b1);
        for (int i = 6; i > 0; i--)
            send_word(i, i == 1);
        drain();

        // Random sets; phase 0 opens with a full store, phases 1 and 2 with one and two past it
        for (int unsigned phase = 0; phase < 3; phase++)
        begin
            idle_pct     = (phase == 0) ? 13 : (phase == 1) ? 82 : 0;
            phase_target = words_sent + RANDOM_WORDS / 3;
            send_set(CAPACITY + phase);
            while (words_sent < phase_target)
            begin
                if ($urandom_range(99) < 40)
                    send_set($urandom_range(3, 1));
                else
                    send_set($urandom_range(12, 4));
            end
            drain();
        end

        repeat (40) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
